// ===== hdl/mhba_pkg.sv =====
// Package for the max-heap block allocator: types, codes and the microcode program.
package mhba_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int KEY_W     = 32;
    localparam int ADDR_W    = 32;
    localparam int HDR_W     = 16;
    localparam logic [HDR_W-1:0] HDR_RESET = 16'd16;
    localparam int S_DATA_W  = 104;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_OCCUPY  = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_NOFIT = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [ADDR_W-1:0] addr;
        logic              free;
    } ent_t;

    typedef struct packed {
        logic [KEY_W-1:0]  entry_size;
        logic [ADDR_W-1:0] entry_address;
        logic              entry_free;
        logic [KEY_W-1:0]  request_size;
    } in_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] address;
        logic [KEY_W-1:0]  size;
        logic [KEY_W-1:0]  capacity;
    } res_t;

    typedef struct packed {
        logic is_insert;
        logic is_extract;
        logic is_occupy;
        logic full;
        logic empty;
        logic at_root;
        logic parent_ge;
        logic nofit;
        logic split;
        logic no_left;
        logic ent_ge_big;
    } flags_t;

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LATCH,
        ACT_INS_START,
        ACT_RD_PARENT,
        ACT_UP_MOVE,
        ACT_PLACE,
        ACT_SET_FULL,
        ACT_SET_EMPTY,
        ACT_SET_NOFIT,
        ACT_EXT_TAKE,
        ACT_OCC_WHOLE,
        ACT_OCC_SPLIT,
        ACT_RD_LAST,
        ACT_REM_LOAD,
        ACT_RD_KIDS,
        ACT_DN_MOVE,
        ACT_EMIT
    } act_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_NEVER,
        COND_NO_IN,
        COND_IS_INSERT,
        COND_IS_EXTRACT,
        COND_IS_OCCUPY,
        COND_FULL,
        COND_EMPTY,
        COND_AT_ROOT,
        COND_PARENT_GE,
        COND_NOFIT,
        COND_SPLIT,
        COND_NO_LEFT,
        COND_ENT_GE_BIG,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [4:0] upc_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    localparam upc_t P_IDLE      = 5'd0;
    localparam upc_t P_DISP      = 5'd1;
    localparam upc_t P_INS       = 5'd5;
    localparam upc_t P_UP        = 5'd7;
    localparam upc_t P_PLACE     = 5'd10;
    localparam upc_t P_ERR_FULL  = 5'd11;
    localparam upc_t P_EXT       = 5'd12;
    localparam upc_t P_OCC       = 5'd14;
    localparam upc_t P_SPLIT     = 5'd18;
    localparam upc_t P_REMOVE    = 5'd19;
    localparam upc_t P_DOWN      = 5'd21;
    localparam upc_t P_ERR_EMPTY = 5'd24;
    localparam upc_t P_ERR_NOFIT = 5'd25;
    localparam upc_t P_FIN       = 5'd26;

    // Control store: a taken condition jumps to target, otherwise fall through.
    function automatic ucode_t mhba_rom(input upc_t a);
        ucode_t w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, target: P_IDLE};
        unique case (a)
            5'd0:  w = '{act: ACT_LATCH,     cond: COND_NO_IN,      target: P_IDLE};
            5'd1:  w = '{act: ACT_NONE,      cond: COND_IS_INSERT,  target: P_INS};
            5'd2:  w = '{act: ACT_NONE,      cond: COND_IS_EXTRACT, target: P_EXT};
            5'd3:  w = '{act: ACT_NONE,      cond: COND_IS_OCCUPY,  target: P_OCC};
            5'd4:  w = '{act: ACT_NONE,      cond: COND_ALWAYS,     target: P_FIN};
            5'd5:  w = '{act: ACT_NONE,      cond: COND_FULL,       target: P_ERR_FULL};
            5'd6:  w = '{act: ACT_INS_START, cond: COND_NEVER,      target: P_IDLE};
            5'd7:  w = '{act: ACT_RD_PARENT, cond: COND_AT_ROOT,    target: P_PLACE};
            5'd8:  w = '{act: ACT_NONE,      cond: COND_PARENT_GE,  target: P_PLACE};
            5'd9:  w = '{act: ACT_UP_MOVE,   cond: COND_ALWAYS,     target: P_UP};
            5'd10: w = '{act: ACT_PLACE,     cond: COND_ALWAYS,     target: P_FIN};
            5'd11: w = '{act: ACT_SET_FULL,  cond: COND_ALWAYS,     target: P_FIN};
            5'd12: w = '{act: ACT_NONE,      cond: COND_EMPTY,      target: P_ERR_EMPTY};
            5'd13: w = '{act: ACT_EXT_TAKE,  cond: COND_ALWAYS,     target: P_REMOVE};
            5'd14: w = '{act: ACT_NONE,      cond: COND_EMPTY,      target: P_ERR_EMPTY};
            5'd15: w = '{act: ACT_NONE,      cond: COND_NOFIT,      target: P_ERR_NOFIT};
            5'd16: w = '{act: ACT_NONE,      cond: COND_SPLIT,      target: P_SPLIT};
            5'd17: w = '{act: ACT_OCC_WHOLE, cond: COND_ALWAYS,     target: P_REMOVE};
            5'd18: w = '{act: ACT_OCC_SPLIT, cond: COND_ALWAYS,     target: P_DOWN};
            5'd19: w = '{act: ACT_RD_LAST,   cond: COND_NEVER,      target: P_IDLE};
            5'd20: w = '{act: ACT_REM_LOAD,  cond: COND_ALWAYS,     target: P_DOWN};
            5'd21: w = '{act: ACT_RD_KIDS,   cond: COND_NO_LEFT,    target: P_PLACE};
            5'd22: w = '{act: ACT_NONE,      cond: COND_ENT_GE_BIG, target: P_PLACE};
            5'd23: w = '{act: ACT_DN_MOVE,   cond: COND_ALWAYS,     target: P_DOWN};
            5'd24: w = '{act: ACT_SET_EMPTY, cond: COND_ALWAYS,     target: P_FIN};
            5'd25: w = '{act: ACT_SET_NOFIT, cond: COND_ALWAYS,     target: P_FIN};
            5'd26: w = '{act: ACT_NONE,      cond: COND_OUT_BUSY,   target: P_FIN};
            5'd27: w = '{act: ACT_EMIT,      cond: COND_ALWAYS,     target: P_IDLE};
            default: w = '{act: ACT_NONE,    cond: COND_ALWAYS,     target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/mhba_seq.sv =====
// Microcode sequencer: program counter, control store lookup and branch evaluation.
module mhba_seq
    import mhba_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    input  logic   out_busy,
    input  flags_t flags,
    output act_t   act
);

    upc_t   upc_reg;
    upc_t   upc_next;
    ucode_t word;
    logic   taken;

    assign word = mhba_rom(upc_reg);
    assign act  = word.act;

    always_comb begin
        unique case (word.cond)
            COND_ALWAYS:     taken = 1'b1;
            COND_NEVER:      taken = 1'b0;
            COND_NO_IN:      taken = !in_valid;
            COND_IS_INSERT:  taken = flags.is_insert;
            COND_IS_EXTRACT: taken = flags.is_extract;
            COND_IS_OCCUPY:  taken = flags.is_occupy;
            COND_FULL:       taken = flags.full;
            COND_EMPTY:      taken = flags.empty;
            COND_AT_ROOT:    taken = flags.at_root;
            COND_PARENT_GE:  taken = flags.parent_ge;
            COND_NOFIT:      taken = flags.nofit;
            COND_SPLIT:      taken = flags.split;
            COND_NO_LEFT:    taken = flags.no_left;
            COND_ENT_GE_BIG: taken = flags.ent_ge_big;
            COND_OUT_BUSY:   taken = out_busy;
            default:         taken = 1'b0;
        endcase
        upc_next = taken ? word.target : upc_reg + upc_t'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= P_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hdl/mhba_datapath.sv =====
// Heap datapath: entry memory, root copy, sift registers, count and header register.
module mhba_datapath
    import mhba_pkg::*;
#(
    parameter  int DEPTH = DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1),
    localparam int IW    = AW + 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  act_t              act,
    input  logic              in_fire,
    input  cmd_t              in_cmd,
    input  in_t               in_word,
    input  logic              cfg_wr_en,
    input  logic [HDR_W-1:0]  cfg_wr_data,
    output flags_t            flags,
    output res_t              res,
    output logic [CW-1:0]     count,
    output logic [KEY_W-1:0]  top_size
);

    ent_t mem [DEPTH];

    logic [CW-1:0]     cnt_reg,  cnt_next;
    logic [HDR_W-1:0]  hdr_reg;
    cmd_t              cmd_reg,  cmd_next;
    logic [KEY_W-1:0]  req_reg,  req_next;
    ent_t              ent_reg,  ent_next;
    logic [AW-1:0]     pos_reg,  pos_next;
    res_t              res_reg,  res_next;
    ent_t              root_reg;
    ent_t              rd_a_reg, rd_b_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ent_t              wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_a_addr, rd_b_addr;

    logic [AW-1:0]     parent_idx;
    logic [IW-1:0]     left_idx, right_idx, cnt_ext;
    logic              right_ok, pick_right;
    ent_t              big;
    logic [AW-1:0]     big_idx;
    logic [KEY_W:0]    cost;

    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign left_idx   = IW'({pos_reg, 1'b1});
    assign right_idx  = left_idx + IW'(1);
    assign cnt_ext    = IW'(cnt_reg);
    assign right_ok   = right_idx < cnt_ext;
    assign pick_right = right_ok && (rd_b_reg.key > rd_a_reg.key);
    assign big        = pick_right ? rd_b_reg : rd_a_reg;
    assign big_idx    = pick_right ? right_idx[AW-1:0] : left_idx[AW-1:0];
    assign cost       = {1'b0, req_reg} + (KEY_W+1)'(hdr_reg);

    assign flags.is_insert  = cmd_reg == CMD_INSERT;
    assign flags.is_extract = cmd_reg == CMD_EXTRACT;
    assign flags.is_occupy  = cmd_reg == CMD_OCCUPY;
    assign flags.full       = cnt_reg == CW'(DEPTH);
    assign flags.empty      = cnt_reg == '0;
    assign flags.at_root    = pos_reg == '0;
    assign flags.parent_ge  = rd_a_reg.key >= ent_reg.key;
    assign flags.nofit      = !root_reg.free || (req_reg > root_reg.key);
    assign flags.split      = {1'b0, root_reg.key} > cost;
    assign flags.no_left    = left_idx >= cnt_ext;
    assign flags.ent_ge_big = ent_reg.key >= big.key;

    assign res      = res_reg;
    assign count    = cnt_reg;
    assign top_size = (cnt_reg != '0) ? root_reg.key : '0;

    always_comb begin
        cnt_next  = cnt_reg;
        cmd_next  = cmd_reg;
        req_next  = req_reg;
        ent_next  = ent_reg;
        pos_next  = pos_reg;
        res_next  = res_reg;
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = ent_reg;
        rd_en     = 1'b0;
        rd_a_addr = parent_idx;
        rd_b_addr = parent_idx;
        unique case (act)
            ACT_LATCH: begin
                if (in_fire) begin
                    cmd_next = in_cmd;
                    req_next = in_word.request_size;
                    ent_next = '{key: in_word.entry_size, addr: in_word.entry_address,
                                 free: in_word.entry_free};
                    res_next = '{status: ST_OK, address: '0, size: '0, capacity: '0};
                end
            end
            ACT_INS_START: begin
                pos_next = cnt_reg[AW-1:0];
                cnt_next = cnt_reg + CW'(1);
            end
            ACT_RD_PARENT: begin
                rd_en = 1'b1;
            end
            ACT_UP_MOVE: begin
                wr_en    = 1'b1;
                wr_data  = rd_a_reg;
                pos_next = parent_idx;
            end
            ACT_PLACE: begin
                wr_en = 1'b1;
            end
            ACT_SET_FULL:  res_next.status = ST_FULL;
            ACT_SET_EMPTY: res_next.status = ST_EMPTY;
            ACT_SET_NOFIT: res_next.status = ST_NOFIT;
            ACT_EXT_TAKE: begin
                res_next = '{status: ST_OK, address: root_reg.addr, size: root_reg.key,
                             capacity: root_reg.key};
            end
            ACT_OCC_WHOLE: begin
                res_next = '{status: ST_OK, address: root_reg.addr, size: req_reg,
                             capacity: root_reg.key};
            end
            ACT_OCC_SPLIT: begin
                res_next = '{status: ST_OK, address: root_reg.addr, size: req_reg,
                             capacity: req_reg};
                ent_next = '{key: root_reg.key - cost[KEY_W-1:0],
                             addr: root_reg.addr + cost[ADDR_W-1:0],
                             free: root_reg.free};
                pos_next = '0;
            end
            ACT_RD_LAST: begin
                rd_en     = 1'b1;
                rd_a_addr = AW'(cnt_reg - CW'(1));
            end
            ACT_REM_LOAD: begin
                ent_next = rd_a_reg;
                cnt_next = cnt_reg - CW'(1);
                pos_next = '0;
            end
            ACT_RD_KIDS: begin
                rd_en     = 1'b1;
                rd_a_addr = left_idx[AW-1:0];
                rd_b_addr = right_ok ? right_idx[AW-1:0] : left_idx[AW-1:0];
            end
            ACT_DN_MOVE: begin
                wr_en    = 1'b1;
                wr_data  = big;
                pos_next = big_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_a_reg <= mem[rd_a_addr];
            rd_b_reg <= mem[rd_b_addr];
        end
        if (wr_en && wr_addr == '0) begin
            root_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        req_reg <= req_next;
        ent_reg <= ent_next;
        pos_reg <= pos_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            hdr_reg <= HDR_RESET;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_wr_en) begin
                hdr_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// ===== hdl/max_heap_block_allocator.sv =====
// Top level of the max-heap block allocator: stream ports and result register.
//
// Keeps up to DEPTH free blocks in a binary max-heap keyed by size. One command
// word enters on the s_ channel (s_tuser selects insert, extract or occupy) and
// exactly one result word leaves on the m_ channel (m_tuser carries the status).
// The user must write header_bytes through cfg_wr_en/cfg_wr_data only while
// the block is idle; the block does not enforce this. A microcoded sequencer
// runs each command over one heap path, reading and writing one level of the
// entry memory per pass. The work for a command depends on how many heap
// levels the moving entry crosses and whether the walk stops at a key compare;
// error results skip the heap walk. One command is worked at a time; s_tready
// rises again the cycle after the result is loaded, even if that result still
// waits.
// A stalled receiver holds the result in the output register; a following
// command is worked up to its result and then waits for that register.
// Reset empties the heap, sets header_bytes to 16 and drops m_tvalid; the entry
// memory is not cleared.
module max_heap_block_allocator
    import mhba_pkg::*;
#(
    parameter  int DEPTH     = DEPTH_DEF,
    localparam int CW        = $clog2(DEPTH + 1),
    localparam int M_DATA_W  = ((3 * KEY_W + CW + KEY_W) + 7) / 8 * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // entry_size, entry_address, entry_free, request_size
    input  logic [S_DATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]          s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // out_address, out_size, out_capacity, entry_count, top_size
    output logic [M_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]          m_tuser,
    input  logic                cfg_wr_en,
    input  logic [HDR_W-1:0]    cfg_wr_data
);

    act_t             act;
    flags_t           flags;
    res_t             res;
    in_t              in_word;
    logic             in_fire;
    logic             out_busy;
    logic [CW-1:0]    count;
    logic [KEY_W-1:0] top_size;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    assign in_word.entry_size    = s_tdata[31:0];
    assign in_word.entry_address = s_tdata[63:32];
    assign in_word.entry_free    = s_tdata[64];
    assign in_word.request_size  = s_tdata[96:65];

    assign s_tready = act == ACT_LATCH;
    assign in_fire  = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;

    mhba_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_busy (out_busy),
        .flags    (flags),
        .act      (act)
    );

    mhba_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .act         (act),
        .in_fire     (in_fire),
        .in_cmd      (cmd_t'(s_tuser)),
        .in_word     (in_word),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .flags       (flags),
        .res         (res),
        .count       (count),
        .top_size    (top_size)
    );

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (act == ACT_EMIT) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (act == ACT_EMIT) begin
            m_tdata_reg <= M_DATA_W'({top_size, count, res.capacity, res.size, res.address});
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
